// ----- rtl/core/pavr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Principal-axis vector rotation: shared definitions
// Fixed widths, axis and quadrant codes, and the arctangent table that the
// rotation-mode CORDIC cells use.
// ----------------------------------------------------------------------------
package pavr_pkg;

    // Internal CORDIC word: x and y with 30 fraction bits, angle on a 2^32 turn.
    localparam int CORDIC_W     = 32;
    // Rounded sine and cosine, 14 fraction bits.
    localparam int TRIG_W       = 16;
    localparam int ANGLE_W      = 16;
    localparam int AXIS_W       = 2;
    localparam int QUAD_W       = 2;
    localparam int ATAN_ENTRIES = 24;

    // Converged CORDIC gain, 0.6072529350 in Q2.30.
    localparam logic [CORDIC_W-1:0] GAIN_Q30 = 32'h26DD3B6A;

    typedef logic [AXIS_W-1:0] axis_t;
    typedef logic [QUAD_W-1:0] quad_t;

    localparam axis_t AXIS_X    = 2'd0;
    localparam axis_t AXIS_Y    = 2'd1;
    localparam axis_t AXIS_Z    = 2'd2;
    localparam axis_t AXIS_PASS = 2'd3;

    localparam quad_t QUAD_0 = 2'd0;
    localparam quad_t QUAD_1 = 2'd1;
    localparam quad_t QUAD_2 = 2'd2;
    localparam quad_t QUAD_3 = 2'd3;

    // atan(2^-idx) on a scale where 2^32 is one full turn.
    function automatic logic [CORDIC_W-1:0] atan_q32(input int unsigned idx);
        logic [CORDIC_W-1:0] r;
        case (idx)
            0:       r = 32'h20000000;
            1:       r = 32'h12E4051E;
            2:       r = 32'h09FB385B;
            3:       r = 32'h051111D4;
            4:       r = 32'h028B0D43;
            5:       r = 32'h0145D7E1;
            6:       r = 32'h00A2F61E;
            7:       r = 32'h00517C55;
            8:       r = 32'h0028BE53;
            9:       r = 32'h00145F2F;
            10:      r = 32'h000A2F98;
            11:      r = 32'h000517CC;
            12:      r = 32'h00028BE6;
            13:      r = 32'h000145F3;
            14:      r = 32'h0000A2FA;
            15:      r = 32'h0000517D;
            16:      r = 32'h000028BE;
            17:      r = 32'h0000145F;
            18:      r = 32'h00000A30;
            19:      r = 32'h00000518;
            20:      r = 32'h0000028C;
            21:      r = 32'h00000146;
            22:      r = 32'h000000A3;
            23:      r = 32'h00000051;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/core/pavr_cordic_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Principal-axis vector rotation: CORDIC cell
// One rotation-mode micro-rotation by a fixed shift, registered, with the
// request's vector, axis and quadrant carried alongside.
// ----------------------------------------------------------------------------
module pavr_cordic_cell #(
    parameter int STAGE  = 0,
    parameter int SIDE_W = 52
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [pavr_pkg::CORDIC_W-1:0]  in_x,
    input  logic signed [pavr_pkg::CORDIC_W-1:0]  in_y,
    input  logic signed [pavr_pkg::CORDIC_W-1:0]  in_z,
    input  logic        [SIDE_W-1:0]              in_side,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [pavr_pkg::CORDIC_W-1:0]  out_x,
    output logic signed [pavr_pkg::CORDIC_W-1:0]  out_y,
    output logic signed [pavr_pkg::CORDIC_W-1:0]  out_z,
    output logic        [SIDE_W-1:0]              out_side
);
    import pavr_pkg::*;

    localparam logic signed [CORDIC_W-1:0] ATAN = atan_q32(STAGE);

    logic                       valid_reg;
    logic signed [CORDIC_W-1:0] x_reg, y_reg, z_reg;
    logic signed [CORDIC_W-1:0] x_next, y_next, z_next;
    logic        [SIDE_W-1:0]   side_reg;
    logic signed [CORDIC_W-1:0] dx, dy;
    logic                       load;

    // The cell takes a request when it is empty or its content moves on.
    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    // Micro-rotation: turn towards zero residual angle, floor shifts.
    always_comb
    begin
        dx = in_y >>> STAGE;
        dy = in_x >>> STAGE;
        if (!in_z[CORDIC_W-1])
        begin
            x_next = in_x - dx;
            y_next = in_y + dy;
            z_next = in_z - ATAN;
        end
        else
        begin
            x_next = in_x + dx;
            y_next = in_y - dy;
            z_next = in_z + ATAN;
        end
    end

    // Occupancy flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // Payload.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_z     = z_reg;
    assign out_side  = side_reg;

endmodule

// ----- rtl/core/pavr_combine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Principal-axis vector rotation: rotate and saturate back end
// Rounds the CORDIC output to sine and cosine, unfolds the quadrant, forms
// the two rotated components with four multipliers, then rounds, saturates
// and places them by axis. Three registered stages.
// ----------------------------------------------------------------------------
module pavr_combine #(
    parameter int COORD_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [pavr_pkg::CORDIC_W-1:0]  in_cos,
    input  logic signed [pavr_pkg::CORDIC_W-1:0]  in_sin,
    input  logic signed [COORD_BITS-1:0]          in_x,
    input  logic signed [COORD_BITS-1:0]          in_y,
    input  logic signed [COORD_BITS-1:0]          in_z,
    input  pavr_pkg::axis_t                       in_axis,
    input  pavr_pkg::quad_t                       in_quad,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [COORD_BITS-1:0]          rot_x,
    output logic signed [COORD_BITS-1:0]          rot_y,
    output logic signed [COORD_BITS-1:0]          rot_z
);
    import pavr_pkg::*;

    localparam int CB    = COORD_BITS;
    localparam int PROD_W = CB + TRIG_W;
    localparam int SUM_W  = PROD_W + 1;

    // Stage valid flags and ready chain.
    logic r_valid_reg, m_valid_reg, s_valid_reg;
    logic r_ready, m_ready, s_ready;

    // Stage R: rounded, unfolded trig values and operands.
    logic signed [CORDIC_W:0]   c_wide, s_wide;
    logic signed [TRIG_W-1:0]   c_rnd, s_rnd;
    logic signed [TRIG_W-1:0]   c_next, s_next;
    logic signed [CB-1:0]       a_next, b_next;
    logic signed [TRIG_W-1:0]   c_reg, s_reg, ns_reg;
    logic signed [CB-1:0]       a_reg, b_reg;
    logic signed [CB-1:0]       rx_reg, ry_reg, rz_reg;
    axis_t                      r_axis_reg;

    // Stage M: products.
    logic signed [PROD_W-1:0]   p0_reg, p1_reg, p2_reg, p3_reg;
    logic signed [CB-1:0]       mx_reg, my_reg, mz_reg;
    axis_t                      m_axis_reg;

    // Stage S: output components.
    logic signed [CB-1:0]       ua, ub;
    logic signed [CB-1:0]       ox_next, oy_next, oz_next;
    logic signed [CB-1:0]       ox_reg, oy_reg, oz_reg;

    // Round half up from Q.26 to Q.12, then clamp to the coordinate range.
    function automatic logic signed [CB-1:0] round_sat(
        input logic signed [PROD_W-1:0] pa,
        input logic signed [PROD_W-1:0] pb
    );
        logic signed [SUM_W-1:0] sum;
        logic signed [SUM_W-1:0] sh;
        logic signed [CB-1:0]    r;
        sum = SUM_W'(pa) + SUM_W'(pb) + SUM_W'(8192);
        sh  = sum >>> 14;
        if (!sh[SUM_W-1] && (|sh[SUM_W-2:CB-1]))
        begin
            r = {1'b0, {(CB-1){1'b1}}};
        end
        else if (sh[SUM_W-1] && !(&sh[SUM_W-2:CB-1]))
        begin
            r = {1'b1, {(CB-1){1'b0}}};
        end
        else
        begin
            r = sh[CB-1:0];
        end
        return r;
    endfunction

    assign s_ready  = !s_valid_reg || out_ready;
    assign m_ready  = !m_valid_reg || s_ready;
    assign r_ready  = !r_valid_reg || m_ready;
    assign in_ready = r_ready;

    // Round Q30 to Q14 and unfold the quadrant; pick the rotated pair (a, b).
    always_comb
    begin
        c_wide = ({in_cos[CORDIC_W-1], in_cos} + (CORDIC_W+1)'(32768)) >>> 16;
        s_wide = ({in_sin[CORDIC_W-1], in_sin} + (CORDIC_W+1)'(32768)) >>> 16;
        c_rnd  = c_wide[TRIG_W-1:0];
        s_rnd  = s_wide[TRIG_W-1:0];
        unique case (in_quad)
            QUAD_0:
            begin
                c_next = c_rnd;
                s_next = s_rnd;
            end
            QUAD_1:
            begin
                c_next = -s_rnd;
                s_next = c_rnd;
            end
            QUAD_2:
            begin
                c_next = -c_rnd;
                s_next = -s_rnd;
            end
            default:
            begin
                c_next = s_rnd;
                s_next = -c_rnd;
            end
        endcase
        unique case (in_axis)
            AXIS_X:
            begin
                a_next = in_y;
                b_next = in_z;
            end
            AXIS_Y:
            begin
                a_next = in_z;
                b_next = in_x;
            end
            default:
            begin
                a_next = in_x;
                b_next = in_y;
            end
        endcase
    end

    // Rotated pair: a' = a*c + b*s, b' = b*c - a*s.
    always_comb
    begin
        ua = round_sat(p0_reg, p1_reg);
        ub = round_sat(p2_reg, p3_reg);
        ox_next = mx_reg;
        oy_next = my_reg;
        oz_next = mz_reg;
        unique case (m_axis_reg)
            AXIS_X:
            begin
                oy_next = ua;
                oz_next = ub;
            end
            AXIS_Y:
            begin
                oz_next = ua;
                ox_next = ub;
            end
            AXIS_Z:
            begin
                ox_next = ua;
                oy_next = ub;
            end
            default:
            begin
                ox_next = mx_reg;
            end
        endcase
    end

    // Valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            s_valid_reg <= 1'b0;
        end
        else
        begin
            if (r_ready)
            begin
                r_valid_reg <= in_valid;
            end
            if (m_ready)
            begin
                m_valid_reg <= r_valid_reg;
            end
            if (s_ready)
            begin
                s_valid_reg <= m_valid_reg;
            end
        end
    end

    // Payload registers of the three stages.
    always_ff @(posedge clk)
    begin
        if (in_valid && r_ready)
        begin
            c_reg      <= c_next;
            s_reg      <= s_next;
            ns_reg     <= -s_next;
            a_reg      <= a_next;
            b_reg      <= b_next;
            rx_reg     <= in_x;
            ry_reg     <= in_y;
            rz_reg     <= in_z;
            r_axis_reg <= in_axis;
        end
        if (r_valid_reg && m_ready)
        begin
            p0_reg     <= a_reg * c_reg;
            p1_reg     <= b_reg * s_reg;
            p2_reg     <= b_reg * c_reg;
            p3_reg     <= a_reg * ns_reg;
            mx_reg     <= rx_reg;
            my_reg     <= ry_reg;
            mz_reg     <= rz_reg;
            m_axis_reg <= r_axis_reg;
        end
        if (m_valid_reg && s_ready)
        begin
            ox_reg <= ox_next;
            oy_reg <= oy_next;
            oz_reg <= oz_next;
        end
    end

    assign out_valid = s_valid_reg;
    assign rot_x     = ox_reg;
    assign rot_y     = oy_reg;
    assign rot_z     = oz_reg;

endmodule

// ----- rtl/core/principal_axis_vector_rotate_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Principal-axis vector rotation unit
// Rotates a Q3.12 vector about the x, y or z axis by a binary angle, or
// passes it through, with saturated Q3.12 results.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_ channel: s_tdata carries vec_x, vec_y, vec_z
//   and angle, s_tuser the axis code. Results leave on the m_ channel with
//   rot_x, rot_y, rot_z in m_tdata, one result for every request, in order.
//   Sine and cosine come from a chain of CORDIC cells, one micro-rotation
//   per cell, followed by a round and unfold stage, a multiply stage and a
//   round and saturate stage.
//   Throughput is one request per cycle while m_tready is high: every
//   stage is a register with its own valid flag, so while the output
//   drains a new request is accepted every cycle.
//   When the receiver holds m_tready low, the finished result waits in the
//   output register while the stages behind it keep filling any empty
//   slots; s_tready falls only once every stage holds a request.
//   Reset empties all stages; no results are pending after it.
// ----------------------------------------------------------------------------
module principal_axis_vector_rotate_unit #(
    parameter int COORD_BITS    = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    // s_tdata fields from bit 0: vec_x, vec_y, vec_z, angle, zero padding.
    input  logic [((3*COORD_BITS+pavr_pkg::ANGLE_W+7)/8)*8-1:0] s_tdata,
    // s_tuser fields from bit 0: axis_code.
    input  pavr_pkg::axis_t                               s_tuser,
    input  logic                                          s_tvalid,
    output logic                                          s_tready,
    // m_tdata fields from bit 0: rot_x, rot_y, rot_z, zero padding.
    output logic [((3*COORD_BITS+7)/8)*8-1:0]             m_tdata,
    output logic                                          m_tvalid,
    input  logic                                          m_tready
);
    import pavr_pkg::*;

    localparam int CB     = COORD_BITS;
    localparam int NSTG   = (CORDIC_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STAGES;
    localparam int SIDE_W = 3*CB + AXIS_W + QUAD_W;
    localparam int OUT_W  = ((3*CB+7)/8)*8;

    // Chain links: index k feeds cell k, index NSTG feeds the back end.
    logic                       lk_valid [NSTG+1];
    logic                       lk_ready [NSTG+1];
    logic signed [CORDIC_W-1:0] lk_x     [NSTG+1];
    logic signed [CORDIC_W-1:0] lk_y     [NSTG+1];
    logic signed [CORDIC_W-1:0] lk_z     [NSTG+1];
    logic        [SIDE_W-1:0]   lk_side  [NSTG+1];

    logic signed [CB-1:0]       vx, vy, vz;
    logic        [ANGLE_W-1:0]  ang;
    logic signed [CB-1:0]       ex, ey, ez;
    axis_t                      e_axis;
    quad_t                      e_quad;
    logic signed [CB-1:0]       rot_x, rot_y, rot_z;

    // Unpack the request and seed the CORDIC with the gain and the residue.
    assign vx  = s_tdata[CB-1:0];
    assign vy  = s_tdata[2*CB-1:CB];
    assign vz  = s_tdata[3*CB-1:2*CB];
    assign ang = s_tdata[3*CB +: ANGLE_W];

    assign lk_valid[0] = s_tvalid;
    assign s_tready    = lk_ready[0];
    assign lk_x[0]     = GAIN_Q30;
    assign lk_y[0]     = '0;
    assign lk_z[0]     = {2'b00, ang[ANGLE_W-3:0], 16'h0000};
    assign lk_side[0]  = {ang[ANGLE_W-1:ANGLE_W-2], s_tuser, vz, vy, vx};

    // Row of CORDIC cells.
    for (genvar k = 0; k < NSTG; k++)
    begin : g_cell
        pavr_cordic_cell #(
            .STAGE  (k),
            .SIDE_W (SIDE_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (lk_valid[k]),
            .in_ready  (lk_ready[k]),
            .in_x      (lk_x[k]),
            .in_y      (lk_y[k]),
            .in_z      (lk_z[k]),
            .in_side   (lk_side[k]),
            .out_valid (lk_valid[k+1]),
            .out_ready (lk_ready[k+1]),
            .out_x     (lk_x[k+1]),
            .out_y     (lk_y[k+1]),
            .out_z     (lk_z[k+1]),
            .out_side  (lk_side[k+1])
        );
    end

    // Split the carried fields at the end of the chain.
    assign ex     = lk_side[NSTG][CB-1:0];
    assign ey     = lk_side[NSTG][2*CB-1:CB];
    assign ez     = lk_side[NSTG][3*CB-1:2*CB];
    assign e_axis = lk_side[NSTG][3*CB +: AXIS_W];
    assign e_quad = lk_side[NSTG][3*CB+AXIS_W +: QUAD_W];

    pavr_combine #(
        .COORD_BITS (CB)
    ) u_combine (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (lk_valid[NSTG]),
        .in_ready  (lk_ready[NSTG]),
        .in_cos    (lk_x[NSTG]),
        .in_sin    (lk_y[NSTG]),
        .in_x      (ex),
        .in_y      (ey),
        .in_z      (ez),
        .in_axis   (e_axis),
        .in_quad   (e_quad),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .rot_x     (rot_x),
        .rot_y     (rot_y),
        .rot_z     (rot_z)
    );

    // Pack the result.
    assign m_tdata = OUT_W'({rot_z, rot_y, rot_x});

endmodule
